// File: rtl/core/kccs_pkg.sv
// Shared types, register indexes, the pin table and the pin mask function.
package kccs_pkg;

    localparam int unsigned KeyW    = 7;
    localparam int unsigned CfgIdxW = 3;

    typedef logic [KeyW-1:0] key_code_t;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_HELP_KEY    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FIRST_FKEY  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_LAST_FKEY   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LEFT_SHIFT  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RIGHT_SHIFT = 3'd4;

    // Reset values of the key code registers.
    localparam key_code_t HELP_KEY_RST    = 7'd95;
    localparam key_code_t FIRST_FKEY_RST  = 7'd80;
    localparam key_code_t LAST_FKEY_RST   = 7'd89;
    localparam key_code_t LEFT_SHIFT_RST  = 7'd96;
    localparam key_code_t RIGHT_SHIFT_RST = 7'd97;

    // Number of function keys F1 to F10.
    localparam key_code_t FKEY_COUNT = 7'd10;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_SHORT = 2'd1,
        MODE_LONG  = 2'd2
    } mode_e;

    typedef struct packed {
        key_code_t help_key;
        key_code_t first_fkey;
        key_code_t last_fkey;
        key_code_t left_shift;
        key_code_t right_shift;
    } key_map_t;

    typedef struct packed {
        mode_e     mode;
        key_code_t key_code;
        logic      key_released;
    } item_t;

    typedef struct packed {
        logic [3:0] memory;
        logic [1:0] rom;
        logic [1:0] extra;
    } sel_t;

    typedef struct packed {
        sel_t       pending;
        logic [7:0] pin_pull_mask;
        logic       store_write;
        logic       applied;
    } result_t;

    function automatic logic [7:0] pin_table(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h4F;
            4'd1:    val = 8'h1B;
            4'd2:    val = 8'h27;
            4'd3:    val = 8'h32;
            4'd4:    val = 8'h00;
            4'd5:    val = 8'h0D;
            4'd6:    val = 8'h09;
            4'd7:    val = 8'h05;
            4'd8:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Each choice owns its own slice of the pin byte.
    function automatic logic [7:0] pin_mask(input sel_t cur);
        logic [7:0] m;
        m = (8'hC0 & pin_table({2'b00, cur.extra}))
          + (8'h30 & pin_table({2'b00, cur.rom}))
          + (8'h0F & pin_table(cur.memory));
        return m;
    endfunction

endpackage

// File: rtl/core/kccs_cfg_regs.sv
// Key code configuration registers.
module kccs_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [kccs_pkg::CfgIdxW-1:0]      cfg_index,
    input  kccs_pkg::key_code_t               cfg_wdata,
    output kccs_pkg::key_map_t                key_map
);

    kccs_pkg::key_map_t map_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg.help_key    <= kccs_pkg::HELP_KEY_RST;
            map_reg.first_fkey  <= kccs_pkg::FIRST_FKEY_RST;
            map_reg.last_fkey   <= kccs_pkg::LAST_FKEY_RST;
            map_reg.left_shift  <= kccs_pkg::LEFT_SHIFT_RST;
            map_reg.right_shift <= kccs_pkg::RIGHT_SHIFT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                kccs_pkg::REG_HELP_KEY:    map_reg.help_key    <= cfg_wdata;
                kccs_pkg::REG_FIRST_FKEY:  map_reg.first_fkey  <= cfg_wdata;
                kccs_pkg::REG_LAST_FKEY:   map_reg.last_fkey   <= cfg_wdata;
                kccs_pkg::REG_LEFT_SHIFT:  map_reg.left_shift  <= cfg_wdata;
                kccs_pkg::REG_RIGHT_SHIFT: map_reg.right_shift <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign key_map = map_reg;

endmodule

// File: rtl/core/kccs_sel_core.sv
// Selection state: shift, function key and help tracking, pending and current choices.
module kccs_sel_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  kccs_pkg::item_t     item,
    input  kccs_pkg::key_map_t  key_map,
    output kccs_pkg::result_t   res
);

    kccs_pkg::sel_t pend_reg, pend_next;
    kccs_pkg::sel_t cur_reg, cur_next;
    logic [1:0]     help_reg, help_next;
    logic [4:0]     fkey_reg, fkey_next;
    logic           shift_reg, shift_next;

    logic                store;
    logic                applied;
    logic                is_shift;
    logic                is_fkey;
    kccs_pkg::key_code_t fkey_off;
    logic [4:0]          fkey_num;
    logic [4:0]          k_mem;
    logic [4:0]          k_rom;
    logic [4:0]          k_extra;
    kccs_pkg::sel_t      commit_sel;

    always_comb begin
        pend_next  = pend_reg;
        cur_next   = cur_reg;
        help_next  = help_reg;
        fkey_next  = fkey_reg;
        shift_next = shift_reg;
        store      = 1'b0;
        applied    = 1'b0;

        is_shift = (item.key_code == key_map.left_shift) ||
                   (item.key_code == key_map.right_shift);
        fkey_off = item.key_code - key_map.first_fkey;
        is_fkey  = (item.key_code >= key_map.first_fkey) &&
                   (item.key_code <= key_map.last_fkey) &&
                   (fkey_off < kccs_pkg::FKEY_COUNT);
        fkey_num = {1'b0, fkey_off[3:0]} + 5'd1 + (shift_reg ? 5'd10 : 5'd0);

        // Commit of the remembered function key into the pending choices.
        k_mem   = fkey_reg - 5'd1;
        k_rom   = fkey_reg - 5'd11;
        k_extra = fkey_reg - 5'd16;
        commit_sel = pend_reg;
        if (fkey_reg >= 5'd1 && fkey_reg <= 5'd10) begin
            commit_sel.memory = k_mem[3:0];
        end else if (fkey_reg >= 5'd11 && fkey_reg <= 5'd14) begin
            commit_sel.rom = k_rom[1:0];
        end else if (fkey_reg >= 5'd16 && fkey_reg <= 5'd19) begin
            commit_sel.extra = k_extra[1:0];
        end
        if (commit_sel.rom == 2'd2 &&
            (commit_sel.memory == 4'd0 || commit_sel.memory == 4'd6)) begin
            commit_sel.rom = 2'd0;
        end

        case (item.mode)
            kccs_pkg::MODE_KEY: begin
                if (!item.key_released) begin
                    if (item.key_code == key_map.help_key) begin
                        if (help_reg != 2'd3) begin
                            help_next = help_reg + 2'd1;
                            if (help_reg == 2'd2) begin
                                pend_next = commit_sel;
                                store     = 1'b1;
                            end
                        end
                    end else begin
                        help_next = 2'd0;
                        fkey_next = 5'd0;
                    end
                    if (is_fkey) begin
                        fkey_next = fkey_num;
                    end
                    if (is_shift) begin
                        shift_next = 1'b1;
                    end
                end else if (is_shift) begin
                    shift_next = 1'b0;
                end
            end
            kccs_pkg::MODE_SHORT: begin
                cur_next = pend_reg;
                applied  = 1'b1;
            end
            kccs_pkg::MODE_LONG: begin
                pend_next = '0;
                store     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            cur_reg   <= '0;
            help_reg  <= 2'd0;
            fkey_reg  <= 5'd0;
            shift_reg <= 1'b0;
        end else if (advance) begin
            pend_reg  <= pend_next;
            cur_reg   <= cur_next;
            help_reg  <= help_next;
            fkey_reg  <= fkey_next;
            shift_reg <= shift_next;
        end
    end

    always_comb begin
        res.pending       = pend_next;
        res.pin_pull_mask = kccs_pkg::pin_mask(cur_next);
        res.store_write   = store;
        res.applied       = applied;
    end

endmodule

// File: rtl/core/keyboard_chord_config_selector.sv
// Top level of the keyboard chord configuration selector.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  tdata: key_code, key_released; tuser: mode
//  m_        out        m_tvalid/m_tready  tdata: pending choices, pin mask;
//                                          tuser: store_write, applied
//  cfg_      in         cfg_we             cfg_index selects the key code register
//
// An accepted event lands in the input register. Once the result register is free
// or drains, the selection logic updates its state and loads the result register,
// which raises m_tvalid. With m_tready high one event flows per cycle.
// While the result register waits on m_tready, the held event stays put and
// s_tready drops, so no transaction is lost. The synchronous active-low reset
// clears the valid flags and the selection state and restores the default key codes.
module keyboard_chord_config_selector (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [6:0] key_code, [7] key_released
    input  logic [1:0]                   s_tuser,   // [1:0] mode

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [3:0] pending_memory,
                                                    // [5:4] pending_rom,
                                                    // [7:6] pending_extra,
                                                    // [15:8] pin_pull_mask
    output logic [1:0]                   m_tuser,   // [0] store_write, [1] applied

    input  logic                         cfg_we,
    input  logic [kccs_pkg::CfgIdxW-1:0] cfg_index,
    input  kccs_pkg::key_code_t          cfg_wdata
);

    logic               in_valid_reg;
    kccs_pkg::item_t    item_reg;
    logic               out_valid_reg;
    kccs_pkg::result_t  res_reg;

    kccs_pkg::key_map_t key_map;
    kccs_pkg::result_t  res;
    kccs_pkg::item_t    s_item;
    logic               advance;
    logic               s_accept;

    // The held event moves on whenever the result register is free or drains now.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        s_item.mode         = kccs_pkg::mode_e'(s_tuser);
        s_item.key_code     = s_tdata[6:0];
        s_item.key_released = s_tdata[7];
    end

    kccs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key_map   (key_map)
    );

    kccs_sel_core u_sel_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .key_map (key_map),
        .res     (res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_item;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.pin_pull_mask, res_reg.pending.extra,
                       res_reg.pending.rom, res_reg.pending.memory};
    assign m_tuser  = {res_reg.applied, res_reg.store_write};

endmodule
